[rtl/core/shcke_pkg.sv]
// ----------------------------------------------------------------------------
// shcke_pkg: shared types and constants of the spatial hash cell key enumerator
// Holds field widths, hash primes, default parameters, the controller state
// type and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package shcke_pkg;

	// default parameter values
	localparam int MAX_SPAN_DEF   = 4;
	localparam int COORD_BITS_DEF = 32;

	// field widths
	localparam int CS_W    = 31;
	localparam int IDX_W   = 32;
	localparam int KEY_W   = 64;
	localparam int PRIME_W = 27;

	// cell pitch after reset: 10.0 in Q16.16
	localparam logic [CS_W-1:0] PITCH_RST = 31'd655360;

	// hash primes
	localparam logic [PRIME_W-1:0] PRIME_X = 27'd73856093;
	localparam logic [PRIME_W-1:0] PRIME_Y = 27'd19349663;
	localparam logic [PRIME_W-1:0] PRIME_Z = 27'd83492791;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RANGE,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	// controller to datapath
	typedef struct packed {
		logic  in_ready;
		logic  start;
		logic  range_ld;
		logic  mul_en;
		axis_t mul_axis;
		logic  step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic empty;
		logic out_free;
		logic last;
	} dp_stat_t;

endpackage

[rtl/core/shcke_if.sv]
// ----------------------------------------------------------------------------
// shcke_if: request channels of the cell key enumerator
// shcke_box_if carries one bounding box request, shcke_key_if one cell key.
// ----------------------------------------------------------------------------
interface shcke_box_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] min_x;
	logic signed [31:0] min_y;
	logic signed [31:0] min_z;
	logic signed [31:0] max_x;
	logic signed [31:0] max_y;
	logic signed [31:0] max_z;

	modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
	modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface shcke_key_if;
	logic               valid;
	logic               ready;
	logic [63:0]        cell_key;
	logic signed [31:0] cell_x;
	logic signed [31:0] cell_y;
	logic signed [31:0] cell_z;
	logic               last_key;
	logic               span_clipped;

	modport source (output valid, cell_key, cell_x, cell_y, cell_z, last_key, span_clipped,
		input ready);
	modport sink (input valid, cell_key, cell_x, cell_y, cell_z, last_key, span_clipped,
		output ready);
endinterface

[rtl/core/shcke_div.sv]
// ----------------------------------------------------------------------------
// shcke_div: serial signed floor divider
// Divides a W-bit signed dividend by a positive 31-bit divisor, one quotient
// bit per cycle on the magnitude, and rounds the result toward minus infinity.
// ----------------------------------------------------------------------------
module shcke_div #(
	parameter int W = shcke_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [W-1:0]                dividend,
	input  logic [shcke_pkg::CS_W-1:0]  divisor,
	output logic                        busy,
	output logic signed [W-1:0]         quot
);
	import shcke_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0]   cnt_q;
	logic [W-1:0]    mag_q;
	logic [CS_W-1:0] rem_q;
	logic [CS_W-1:0] dsr_q;
	logic            neg_q;
	logic [CS_W:0]   trial;
	logic            fits;
	logic [W-1:0]    mag_ld;

	// magnitude of the dividend
	assign mag_ld = dividend[W-1] ? (~dividend + 1'b1) : dividend;

	// one restoring step
	assign trial = {rem_q, mag_q[W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});
	assign busy  = (cnt_q != '0);

	// count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift quotient bits into the magnitude register
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1];
			mag_q <= mag_ld;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? CS_W'(trial - {1'b0, dsr_q}) : trial[CS_W-1:0];
			mag_q <= {mag_q[W-2:0], fits};
		end
	end

	// negate, and step down once more on a nonzero remainder
	always_comb begin
		if (!neg_q) begin
			quot = mag_q;
		end else if (rem_q != '0) begin
			quot = ~mag_q;
		end else begin
			quot = ~mag_q + 1'b1;
		end
	end

endmodule

[rtl/core/shcke_ctrl.sv]
// ----------------------------------------------------------------------------
// shcke_ctrl: sequencer of the cell key enumerator
// Steps one box through divide, range check, base hash multiply and key
// emission, and issues the datapath commands for each phase.
// ----------------------------------------------------------------------------
module shcke_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  shcke_pkg::dp_stat_t   stat,
	output shcke_pkg::ctrl_cmd_t  cmd
);
	import shcke_pkg::*;

	state_t state_q;
	state_t state_d;
	axis_t  mul_axis_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) state_d = ST_RANGE;
			end
			ST_RANGE: begin
				state_d = stat.empty ? ST_IDLE : ST_MUL;
			end
			ST_MUL: begin
				if (mul_axis_q == AX_Z) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free && stat.last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.mul_axis = mul_axis_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.start    = stat.in_valid;
			end
			ST_RANGE: begin
				cmd.range_ld = 1'b1;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_EMIT: begin
				cmd.step = stat.out_free;
			end
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance the multiply axis, x then y then z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_axis_q <= AX_X;
		end else if (state_q == ST_MUL) begin
			unique case (mul_axis_q)
				AX_X:    mul_axis_q <= AX_Y;
				AX_Y:    mul_axis_q <= AX_Z;
				default: mul_axis_q <= AX_X;
			endcase
		end
	end

	a_step_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !stat.div_busy)
		else $error("key emitted while dividers still busy");

	a_start_runs_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> stat.div_busy)
		else $error("dividers not running after box request taken");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.range_ld, cmd.mul_en, cmd.step}))
		else $error("more than one datapath phase commanded");

endmodule

[rtl/core/shcke_dp.sv]
// ----------------------------------------------------------------------------
// shcke_dp: datapath of the cell key enumerator
// Holds the cell size register, six floor dividers, the range limits, the
// running cell indices and partial hashes, and the output register.
// ----------------------------------------------------------------------------
module shcke_dp #(
	parameter int MAX_SPAN   = shcke_pkg::MAX_SPAN_DEF,
	parameter int COORD_BITS = shcke_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [shcke_pkg::CS_W-1:0] cfg_wdata,
	shcke_box_if.sink                  box_in,
	shcke_key_if.source                key_out,
	input  shcke_pkg::ctrl_cmd_t       cmd,
	output shcke_pkg::dp_stat_t        stat
);
	import shcke_pkg::*;

	localparam int LW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
	localparam int PW = IDX_W + PRIME_W + 1;

	logic [CS_W-1:0]              pitch_q;
	logic [CS_W-1:0]              divisor;
	logic [COORD_BITS-1:0]        dvd [6];
	logic signed [COORD_BITS-1:0] quot [6];
	logic [5:0]                   busy;
	logic signed [IDX_W-1:0]      qs [6];
	logic [2:0]                   rev;
	logic [2:0]                   clip;
	logic [IDX_W:0]               span [3];
	logic [LW-1:0]                limv [3];
	logic [LW-1:0]                lim_q [3];
	logic                         clip_q;
	logic [LW-1:0]                cnt_q [3];
	logic signed [IDX_W-1:0]      cur_q [3];
	logic [2:0]                   at_lim;
	logic signed [IDX_W-1:0]      mul_a;
	logic signed [PRIME_W:0]      mul_b;
	logic signed [PW-1:0]         prod;
	logic [KEY_W-1:0]             prod64;
	logic [KEY_W-1:0]             hx_q;
	logic [KEY_W-1:0]             hy_q;
	logic [KEY_W-1:0]             hz_q;
	logic [KEY_W-1:0]             hyb_q;
	logic [KEY_W-1:0]             hzb_q;
	logic                         ov_q;
	logic                         last;

	// cell size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RST;
		end else if (cfg_we) begin
			pitch_q <= cfg_wdata;
		end
	end

	// treat a zero cell size as the smallest step
	assign divisor = (pitch_q == '0) ? CS_W'(1) : pitch_q;

	assign dvd[0] = box_in.min_x[COORD_BITS-1:0];
	assign dvd[1] = box_in.min_y[COORD_BITS-1:0];
	assign dvd[2] = box_in.min_z[COORD_BITS-1:0];
	assign dvd[3] = box_in.max_x[COORD_BITS-1:0];
	assign dvd[4] = box_in.max_y[COORD_BITS-1:0];
	assign dvd[5] = box_in.max_z[COORD_BITS-1:0];

	// six floor dividers, run side by side
	for (genvar g = 0; g < 6; g++) begin : g_div
		shcke_div #(.W(COORD_BITS)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (cmd.start),
			.dividend (dvd[g]),
			.divisor  (divisor),
			.busy     (busy[g]),
			.quot     (quot[g])
		);
		assign qs[g] = IDX_W'(quot[g]);
	end

	// per axis: reversed range, span and clipped limit
	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign rev[a]  = (qs[a+3] < qs[a]);
		assign span[a] = {qs[a+3][IDX_W-1], qs[a+3]} - {qs[a][IDX_W-1], qs[a]};
		assign clip[a] = (span[a] > (IDX_W+1)'(MAX_SPAN - 1));
		assign limv[a] = clip[a] ? LW'(MAX_SPAN - 1) : span[a][LW-1:0];
		assign at_lim[a] = (cnt_q[a] == lim_q[a]);
	end

	assign last = &at_lim;

	// base hash operands for the selected axis
	always_comb begin
		unique case (cmd.mul_axis)
			AX_X: begin
				mul_a = qs[0];
				mul_b = {1'b0, PRIME_X};
			end
			AX_Y: begin
				mul_a = qs[1];
				mul_b = {1'b0, PRIME_Y};
			end
			AX_Z: begin
				mul_a = qs[2];
				mul_b = {1'b0, PRIME_Z};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign prod64 = KEY_W'(prod);

	// latch limits, walk the cells and keep the partial hashes
	always_ff @(posedge clk) begin
		if (cmd.range_ld) begin
			for (int a = 0; a < 3; a++) begin
				lim_q[a] <= limv[a];
				cnt_q[a] <= '0;
				cur_q[a] <= qs[a];
			end
			clip_q <= |clip;
		end else if (cmd.mul_en) begin
			unique case (cmd.mul_axis)
				AX_X: begin
					hx_q <= prod64;
				end
				AX_Y: begin
					hy_q  <= prod64;
					hyb_q <= prod64;
				end
				AX_Z: begin
					hz_q  <= prod64;
					hzb_q <= prod64;
				end
				default: begin
					hx_q <= hx_q;
				end
			endcase
		end else if (cmd.step) begin
			if (!at_lim[2]) begin
				cnt_q[2] <= cnt_q[2] + 1'b1;
				cur_q[2] <= cur_q[2] + 1'b1;
				hz_q     <= hz_q + KEY_W'(PRIME_Z);
			end else begin
				cnt_q[2] <= '0;
				cur_q[2] <= qs[2];
				hz_q     <= hzb_q;
				if (!at_lim[1]) begin
					cnt_q[1] <= cnt_q[1] + 1'b1;
					cur_q[1] <= cur_q[1] + 1'b1;
					hy_q     <= hy_q + KEY_W'(PRIME_Y);
				end else begin
					cnt_q[1] <= '0;
					cur_q[1] <= qs[1];
					hy_q     <= hyb_q;
					cnt_q[0] <= cnt_q[0] + 1'b1;
					cur_q[0] <= cur_q[0] + 1'b1;
					hx_q     <= hx_q + KEY_W'(PRIME_X);
				end
			end
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.step) begin
			ov_q <= 1'b1;
		end else if (key_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			key_out.cell_key     <= hx_q ^ hy_q ^ hz_q;
			key_out.cell_x       <= cur_q[0];
			key_out.cell_y       <= cur_q[1];
			key_out.cell_z       <= cur_q[2];
			key_out.last_key     <= last;
			key_out.span_clipped <= clip_q;
		end
	end

	assign key_out.valid = ov_q;
	assign box_in.ready  = cmd.in_ready;

	// status to the controller
	assign stat.in_valid = box_in.valid;
	assign stat.div_busy = |busy;
	assign stat.empty    = |rev;
	assign stat.out_free = !ov_q || key_out.ready;
	assign stat.last     = last;

	a_last_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && last) |=> (key_out.valid && key_out.last_key))
		else $error("final key of a box not flagged at the output");

endmodule

[rtl/core/spatial_hash_cell_key_enumerator.sv]
// ----------------------------------------------------------------------------
// spatial_hash_cell_key_enumerator: grid cell keys of a bounding box
// Floors a box's corners to cell indices and emits one hashed key per cell.
// ----------------------------------------------------------------------------
// Usage:
//   box_in takes one box request (signed Q16.16 min and max corners).
//   key_out returns one request per cell in the box, x outermost and z
//   innermost, with last_key set on the final one and span_clipped set on
//   every key of a box where an axis covered more than MAX_SPAN cells.
//   A box with a reversed range on any axis returns nothing.
//   The cell size is written through cfg_we/cfg_wdata while the block is idle.
// Timing:
//   Six floor dividers run in parallel, one quotient bit per cycle. A range
//   check and the shared base hash multiplier, used once per axis, follow;
//   then keys leave at one key per cycle while key_out is not stalled.
//   A box with no cells returns to idle after the range check.
// Reset and stall:
//   arst_n clears the sequencer and output valid and loads the cell size with
//   10.0. A stalled key_out holds the current key; enumeration waits on it.
//   The next box is taken once the final key sits in the output register.
// ----------------------------------------------------------------------------
module spatial_hash_cell_key_enumerator #(
	parameter int MAX_SPAN   = shcke_pkg::MAX_SPAN_DEF,
	parameter int COORD_BITS = shcke_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [shcke_pkg::CS_W-1:0] cfg_wdata,
	shcke_box_if.sink                  box_in,
	shcke_key_if.source                key_out
);
	import shcke_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer
	shcke_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath
	shcke_dp #(
		.MAX_SPAN   (MAX_SPAN),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.box_in    (box_in),
		.key_out   (key_out),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
